FILE: rtl/hdf_pkg.sv
package hdf_pkg;

  localparam int NUM_W          = 20;
  localparam int LC_W           = 14;
  localparam int DECIMAL_DIGITS = 6;
  localparam int SUM_DIGITS     = 3;
  localparam int BCD_W          = 4;
  localparam int MAX_COUNT      = 16383;
  localparam int CNT_W          = $clog2(MAX_COUNT + 1);
  localparam int STEP_CAP       = 64;
  localparam int STEP_W         = $clog2(STEP_CAP);
  localparam int CONV_W         = $clog2(NUM_W);
  localparam int DCNT_W         = $clog2(DECIMAL_DIGITS);
  localparam int ACC_W          = SUM_DIGITS * BCD_W;
  localparam int START_W        = DECIMAL_DIGITS * BCD_W;
  localparam longint unsigned DEC_LIMIT = 64'(10 ** DECIMAL_DIGITS) - 64'd1;

  localparam logic [ACC_W-1:0] BCD_ONE = ACC_W'(12'h001);

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SQUARE,
    ST_CHECK,
    ST_RESULT
  } state_t;

  function automatic logic [7:0] square_bcd(input logic [BCD_W-1:0] d);
    logic [7:0] q;
    case (d)
      4'd0:    q = 8'h00;
      4'd1:    q = 8'h01;
      4'd2:    q = 8'h04;
      4'd3:    q = 8'h09;
      4'd4:    q = 8'h16;
      4'd5:    q = 8'h25;
      4'd6:    q = 8'h36;
      4'd7:    q = 8'h49;
      4'd8:    q = 8'h64;
      4'd9:    q = 8'h81;
      default: q = 8'h00;
    endcase
    return q;
  endfunction

  function automatic logic [ACC_W-1:0] bcd_add(input logic [ACC_W-1:0] a,
                                               input logic [7:0] q);
    logic [4:0] ones;
    logic [4:0] tens;
    logic       c0;
    logic       c1;
    logic [ACC_W-1:0] r;
    ones = {1'b0, a[3:0]} + {1'b0, q[3:0]};
    c0   = (ones > 5'd9);
    if (c0) begin
      ones = ones - 5'd10;
    end
    tens = {1'b0, a[7:4]} + {1'b0, q[7:4]} + {4'd0, c0};
    c1   = (tens > 5'd9);
    if (c1) begin
      tens = tens - 5'd10;
    end
    r = a;
    r[3:0]  = ones[3:0];
    r[7:4]  = tens[3:0];
    r[11:8] = a[11:8] + {3'd0, c1};
    return r;
  endfunction

  function automatic logic in_sad_cycle(input logic [ACC_W-1:0] v);
    return (v == ACC_W'(12'h004)) || (v == ACC_W'(12'h016)) ||
           (v == ACC_W'(12'h037)) || (v == ACC_W'(12'h058)) ||
           (v == ACC_W'(12'h089)) || (v == ACC_W'(12'h145)) ||
           (v == ACC_W'(12'h042)) || (v == ACC_W'(12'h020));
  endfunction

endpackage

FILE: rtl/hdf_in_if.sv
interface hdf_in_if;
  logic                        valid;
  logic                        ready;
  logic [hdf_pkg::NUM_W-1:0]   number;
  logic                        last_item;

  modport source (output valid, number, last_item, input ready);
  modport sink   (input valid, number, last_item, output ready);
endinterface

FILE: rtl/hdf_out_if.sv
interface hdf_out_if;
  logic                        valid;
  logic                        ready;
  logic [hdf_pkg::NUM_W-1:0]   echoed_number;
  logic                        is_leader;
  logic [hdf_pkg::LC_W-1:0]    leader_count;
  logic                        end_of_array;

  modport source (output valid, echoed_number, is_leader, leader_count, end_of_array,
                  input ready);
  modport sink   (input valid, echoed_number, is_leader, leader_count, end_of_array,
                  output ready);
endinterface

FILE: rtl/hdf_cell.sv
module hdf_cell (
  input  logic                        clk,
  input  hdf_pkg::cell_op_t           op,
  input  logic                        bit_in,
  input  logic [hdf_pkg::BCD_W-1:0]   upper_digit,
  input  logic [hdf_pkg::BCD_W-1:0]   load_digit,
  output logic [hdf_pkg::BCD_W-1:0]   digit,
  output logic                        carry
);

  logic [hdf_pkg::BCD_W-1:0] adj;

  always_comb begin
    adj   = (digit >= 4'd5) ? digit + 4'd3 : digit;
    carry = adj[hdf_pkg::BCD_W-1];
  end

  always_ff @(posedge clk) begin
    case (op)
      hdf_pkg::CELL_LOAD:   digit <= load_digit;
      hdf_pkg::CELL_DABBLE: digit <= {adj[hdf_pkg::BCD_W-2:0], bit_in};
      hdf_pkg::CELL_SHIFT:  digit <= upper_digit;
      default:              digit <= digit;
    endcase
  end

endmodule

FILE: rtl/happy_number_filter_unit.sv
// A number that is zero or above the decimal range goes straight to the result;
//   any other is converted to BCD, then runs through at most 64 digit-square steps.
// The next number is taken only once the result of the last one is registered,
//   which waits while the result slot is full.
// Each step shifts the digit cells once per cycle into one square-and-add unit.
// Reset clears the state machine, the result slot and the leader count at once.
module happy_number_filter_unit (
  input  logic            clk,
  input  logic            rst,
  hdf_in_if.sink          items,
  hdf_out_if.source       results
);

  localparam int D = hdf_pkg::DECIMAL_DIGITS;
  localparam int W = hdf_pkg::BCD_W;

  hdf_pkg::state_t   state;
  hdf_pkg::state_t   state_next;
  hdf_pkg::cell_op_t cell_op;

  logic [W-1:0] digits      [D];
  logic [W-1:0] load_digits [D];
  logic         carries     [D];

  logic [hdf_pkg::NUM_W-1:0]   number;
  logic                        last_item;
  logic [hdf_pkg::NUM_W-1:0]   shreg;
  logic [hdf_pkg::CONV_W-1:0]  conv_cnt;
  logic [hdf_pkg::DCNT_W-1:0]  dcnt;
  logic [hdf_pkg::DCNT_W-1:0]  dcnt_last;
  logic [hdf_pkg::STEP_W-1:0]  step;
  logic                        first;
  logic [hdf_pkg::ACC_W-1:0]   acc;
  logic [hdf_pkg::START_W-1:0] start;
  logic                        leader;
  logic [hdf_pkg::CNT_W-1:0]   running;
  logic [hdf_pkg::CNT_W-1:0]   running_next;
  logic                        out_valid;
  logic                        slot_free;
  logic                        accept;
  logic                        trivial;
  logic                        finished;

  genvar gi;
  generate
    for (gi = 0; gi < D; gi++) begin : g_cell
      logic         bit_in;
      logic [W-1:0] upper;
      if (gi == 0) begin : g_low
        assign bit_in = shreg[hdf_pkg::NUM_W-1];
      end else begin : g_mid
        assign bit_in = carries[gi-1];
      end
      if (gi == D - 1) begin : g_top
        assign upper = '0;
      end else begin : g_below
        assign upper = digits[gi+1];
      end
      if (gi < hdf_pkg::SUM_DIGITS) begin : g_sum
        assign load_digits[gi] = (state == hdf_pkg::ST_CHECK) ? acc[gi*W +: W] : '0;
      end else begin : g_pad
        assign load_digits[gi] = '0;
      end
      hdf_cell u_cell (
        .clk         (clk),
        .op          (cell_op),
        .bit_in      (bit_in),
        .upper_digit (upper),
        .load_digit  (load_digits[gi]),
        .digit       (digits[gi]),
        .carry       (carries[gi])
      );
    end
  endgenerate

  assign accept    = items.valid && items.ready;
  assign trivial   = (items.number == '0) || (64'(items.number) > hdf_pkg::DEC_LIMIT);
  assign dcnt_last = first ? hdf_pkg::DCNT_W'(D - 1) : hdf_pkg::DCNT_W'(hdf_pkg::SUM_DIGITS - 1);
  assign finished  = (acc == hdf_pkg::BCD_ONE) ||
                     (start == hdf_pkg::START_W'(acc)) ||
                     hdf_pkg::in_sad_cycle(acc) ||
                     (step == hdf_pkg::STEP_W'(hdf_pkg::STEP_CAP - 1));
  assign slot_free = !out_valid || results.ready;
  assign running_next = (leader && running != hdf_pkg::CNT_W'(hdf_pkg::MAX_COUNT)) ?
                        running + 1'b1 : running;

  always_comb begin
    state_next = state;
    case (state)
      hdf_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = trivial ? hdf_pkg::ST_RESULT : hdf_pkg::ST_CONVERT;
        end
      end
      hdf_pkg::ST_CONVERT: begin
        if (conv_cnt == hdf_pkg::CONV_W'(hdf_pkg::NUM_W - 1)) begin
          state_next = hdf_pkg::ST_SQUARE;
        end
      end
      hdf_pkg::ST_SQUARE: begin
        if (dcnt == dcnt_last) begin
          state_next = hdf_pkg::ST_CHECK;
        end
      end
      hdf_pkg::ST_CHECK: begin
        state_next = finished ? hdf_pkg::ST_RESULT : hdf_pkg::ST_SQUARE;
      end
      hdf_pkg::ST_RESULT: begin
        if (slot_free) begin
          state_next = hdf_pkg::ST_IDLE;
        end
      end
      default: state_next = hdf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    items.ready = 1'b0;
    cell_op     = hdf_pkg::CELL_HOLD;
    case (state)
      hdf_pkg::ST_IDLE: begin
        items.ready = 1'b1;
        cell_op     = hdf_pkg::CELL_LOAD;
      end
      hdf_pkg::ST_CONVERT: cell_op = hdf_pkg::CELL_DABBLE;
      hdf_pkg::ST_SQUARE:  cell_op = hdf_pkg::CELL_SHIFT;
      hdf_pkg::ST_CHECK:   cell_op = hdf_pkg::CELL_LOAD;
      default:             cell_op = hdf_pkg::CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hdf_pkg::ST_IDLE;
      out_valid <= 1'b0;
      running   <= '0;
    end else begin
      state <= state_next;
      if (state == hdf_pkg::ST_RESULT && slot_free) begin
        out_valid <= 1'b1;
        running   <= last_item ? '0 : running_next;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      hdf_pkg::ST_IDLE: begin
        if (accept) begin
          number    <= items.number;
          last_item <= items.last_item;
          shreg     <= items.number;
          conv_cnt  <= '0;
          leader    <= 1'b0;
        end
      end
      hdf_pkg::ST_CONVERT: begin
        shreg    <= shreg << 1;
        conv_cnt <= conv_cnt + 1'b1;
        acc      <= '0;
        dcnt     <= '0;
        first    <= 1'b1;
        step     <= '0;
      end
      hdf_pkg::ST_SQUARE: begin
        acc  <= hdf_pkg::bcd_add(acc, hdf_pkg::square_bcd(digits[0]));
        dcnt <= dcnt + 1'b1;
        if (first && dcnt == '0) begin
          for (int i = 0; i < D; i++) begin
            start[i*W +: W] <= digits[i];
          end
        end
      end
      hdf_pkg::ST_CHECK: begin
        acc    <= '0;
        dcnt   <= '0;
        first  <= 1'b0;
        step   <= step + 1'b1;
        leader <= (acc == hdf_pkg::BCD_ONE);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == hdf_pkg::ST_RESULT && slot_free) begin
      results.echoed_number <= number;
      results.is_leader     <= leader;
      results.leader_count  <= hdf_pkg::LC_W'(running_next);
      results.end_of_array  <= last_item;
    end
  end

  assign results.valid = out_valid;

  a_reset_empty: assert property (@(posedge clk) rst |=> !results.valid)
    else $error("result slot not empty after reset");

  a_leader_nonzero: assert property (@(posedge clk) disable iff (rst)
      results.valid && results.is_leader |-> results.echoed_number != '0)
    else $error("zero flagged as leader");

  a_count_clears: assert property (@(posedge clk) disable iff (rst)
      state == hdf_pkg::ST_RESULT && slot_free && last_item |=> running == '0)
    else $error("leader count not cleared after last word");

  a_upper_zero: assert property (@(posedge clk) disable iff (rst)
      state == hdf_pkg::ST_SQUARE && !first |-> digits[D-1] == '0)
    else $error("top digit cell not empty after first step");

endmodule
